### rtl/ffnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffnf_pkg;

   // signed coordinate wide enough for a neighbour two steps outside the 8-bit range
   localparam int COORD_W = 10;
   typedef logic signed [COORD_W-1:0] coord_type;

   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd1;
   localparam csr_index_type CSR_FADE_AMOUNT  = 2'd2;
   localparam csr_index_type CSR_DISP_MODE    = 2'd3;

   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_COMPUTE = 1'b1;

   typedef logic [1:0] disp_type;
   localparam disp_type DISP_STATIC = 2'd0;
   localparam disp_type DISP_MOTION = 2'd1;
   localparam disp_type DISP_BLOW   = 2'd2;
   localparam disp_type DISP_SPIN   = 2'd3;

   localparam int NUM_TAPS   = 9;
   localparam int CENTRE_TAP = 4;
   localparam int TAP_W      = 4;
   typedef logic [TAP_W-1:0] tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // 3x3 window scanned row by row, centre in the middle
   function automatic coord_type tap_dcol(input tap_type t);
      coord_type d;
      case (t)
         4'd0, 4'd3, 4'd6: d = -coord_type'(1);
         4'd2, 4'd5, 4'd8: d = coord_type'(1);
         default:          d = '0;
      endcase
      return d;
   endfunction

   function automatic coord_type tap_drow(input tap_type t);
      coord_type d;
      case (t)
         4'd0, 4'd1, 4'd2: d = -coord_type'(1);
         4'd6, 4'd7, 4'd8: d = coord_type'(1);
         default:          d = '0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

### rtl/fire_fade_neighbourhood_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake          | payload
// request   | in        | start / busy       | req_mode, req_pos_x, req_pos_y, req_pixel_in
// result    | out       | rsp_valid strobe   | rsp_pixel_out
// csr       | in        | csr_write          | csr_index, csr_wdata
//
// a write word goes into the frame store at the edge that accepts it; busy stays low
// a compute word keeps busy high through setup, the nine reads of the 3x3 window
// through the single frame store port (one read per cycle), drain and finish
// rsp_valid pulses for one cycle, registered from the finish state that ends the scan
// reset sets width 256, height 256, fade 0, static mode; the frame store is not cleared
// the receiver cannot stall, so a result is never held back
module fire_fade_neighbourhood_filter_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_mode,
   input  wire logic [7:0]             req_pos_x,
   input  wire logic [7:0]             req_pos_y,
   input  wire logic [31:0]            req_pixel_in,
   output logic                        rsp_valid,
   output logic [31:0]                 rsp_pixel_out,
   input  wire logic                   csr_write,
   input  wire ffnf_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata
);
   import ffnf_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic [31:0] frame_mem [0:DEPTH-1];

   state_type   state_ff, state_in;
   logic [8:0]  width_ff, height_ff;
   logic [31:0] fade_ff;
   disp_type    disp_ff;

   logic [7:0]  x_ff, y_ff;
   coord_type   src_x_ff, src_y_ff, src_x_in, src_y_in;
   tap_type     tap_ff, tap_in;

   logic        rd_live_ff, rd_frame_ff, rd_centre_ff;
   logic [31:0] rd_data_ff;
   logic [10:0] nsum_ff [4];
   logic [31:0] centre_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_pixel_ff, rsp_pixel_in;

   logic        accept, wr_en, rd_en, clear_acc, finish;
   logic [8:0]  w_eff, h_eff;
   coord_type   dx, dy, ax, ay, nx, ny;
   logic        in_frame;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0] rd_masked;

   assign accept = start && !busy;
   assign wr_en  = accept && (req_mode == MODE_WRITE) && (32'(req_pos_x) < MAX_WIDTH)
                   && (32'(req_pos_y) < MAX_HEIGHT);
   assign wr_addr = AW'(req_pos_y) * AW'(MAX_WIDTH) + AW'(req_pos_x);

   // effective frame size: zero counts as one, above the store saturates
   always_comb begin
      if (width_ff == '0) w_eff = 9'd1;
      else if (32'(width_ff) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = 9'd1;
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   // source point from the displacement mode
   always_comb begin
      dx = coord_type'({2'b00, x_ff}) - coord_type'({2'b00, w_eff[8:1]});
      dy = coord_type'({2'b00, y_ff}) - coord_type'({2'b00, h_eff[8:1]});
      ax = dx[COORD_W-1] ? -dx : dx;
      ay = dy[COORD_W-1] ? -dy : dy;
      src_x_in = coord_type'({2'b00, x_ff});
      src_y_in = coord_type'({2'b00, y_ff});
      case (disp_ff)
         DISP_STATIC: ;
         DISP_MOTION: src_y_in = src_y_in + coord_type'(1);
         DISP_BLOW: begin
            if (ax >= ay) src_x_in = dx[COORD_W-1] ? src_x_in + coord_type'(1)
                                                   : src_x_in - coord_type'(1);
            if (ay >= ax) src_y_in = dy[COORD_W-1] ? src_y_in + coord_type'(1)
                                                   : src_y_in - coord_type'(1);
         end
         DISP_SPIN: begin
            if (dx > 0) begin
               if (dy > 0) src_y_in = src_y_in - coord_type'(1);
               else src_x_in = src_x_in - coord_type'(1);
            end else begin
               if (dy > 0) src_x_in = src_x_in + coord_type'(1);
               else src_y_in = src_y_in + coord_type'(1);
            end
         end
         default: ;
      endcase
   end

   // neighbour address for the current tap
   always_comb begin
      nx = src_x_ff + tap_dcol(tap_ff);
      ny = src_y_ff + tap_drow(tap_ff);
      in_frame = !nx[COORD_W-1] && !ny[COORD_W-1] &&
                 (nx[8:0] < w_eff) && (ny[8:0] < h_eff);
      rd_addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && req_mode == MODE_COMPUTE) state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_READ;
         ST_READ:   if (tap_ff == tap_type'(NUM_TAPS - 1)) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rd_en     = (state_ff == ST_READ);
      clear_acc = (state_ff == ST_SETUP);
      finish    = (state_ff == ST_FINISH);
      tap_in    = ((state_ff == ST_READ) && (tap_ff != tap_type'(NUM_TAPS - 1)))
                  ? tap_ff + tap_type'(1) : '0;
   end

   assign rd_masked = rd_frame_ff ? rd_data_ff : '0;

   always_comb begin
      logic [8:0] avg;
      logic [8:0] diff;
      rsp_pixel_in = '0;
      for (int ch = 0; ch < 4; ch++) begin
         avg  = {1'b0, nsum_ff[ch][10:3]} + {1'b0, centre_ff[ch*8 +: 8]};
         diff = {1'b0, avg[8:1]} - {1'b0, fade_ff[ch*8 +: 8]};
         rsp_pixel_in[ch*8 +: 8] = diff[8] ? 8'd0 : diff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[wr_addr] <= req_pixel_in;
      if (rd_en) rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         fade_ff      <= '0;
         disp_ff      <= DISP_STATIC;
         tap_ff       <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rd_live_ff   <= rd_en;
         rsp_valid_ff <= finish;
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[8:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata[8:0];
               CSR_FADE_AMOUNT:  fade_ff   <= csr_wdata;
               CSR_DISP_MODE:    disp_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
      end
      if (clear_acc) begin
         src_x_ff <= src_x_in;
         src_y_ff <= src_y_in;
      end
      rd_frame_ff  <= in_frame;
      rd_centre_ff <= (tap_ff == tap_type'(CENTRE_TAP));
      if (clear_acc) begin
         for (int ch = 0; ch < 4; ch++) nsum_ff[ch] <= '0;
         centre_ff <= '0;
      end else if (rd_live_ff) begin
         if (rd_centre_ff) centre_ff <= rd_masked;
         else begin
            for (int ch = 0; ch < 4; ch++)
               nsum_ff[ch] <= nsum_ff[ch] + {3'b000, rd_masked[ch*8 +: 8]};
         end
      end
      if (finish) rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   a_compute_enters_setup: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_COMPUTE) |=> (state_ff == ST_SETUP))
      else $error("compute word did not start the window scan");

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_FINISH))
      else $error("result strobe without a finished scan");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= tap_type'(NUM_TAPS - 1))
      else $error("tap counter past the window");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("frame store written during a scan");

   a_drain_after_last_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_live_ff && $past(tap_ff) == tap_type'(NUM_TAPS - 1)))
      else $error("scan ended before the last tap was read");

endmodule
`default_nettype wire
